### src/wvr_pkg.sv
// Package: shared widths, codes and types for the vertex weld and remap block.
package wvr_pkg;

	localparam int MAX_VERTICES = 1024;
	localparam int FRAC_BITS    = 16;

	localparam int IDX_W     = $clog2(MAX_VERTICES);
	localparam int CNT_W     = $clog2(MAX_VERTICES + 1);
	localparam int OUT_IDX_W = 10;
	localparam int COORD_W   = 32;
	localparam int TOL_W     = 31;
	localparam int TOL_SQ_W  = 2 * TOL_W;
	localparam int SUM_W     = 64;
	localparam int CMD_W     = 2;
	localparam int STATUS_W  = 2;
	localparam int SURV_W    = 3 * COORD_W;

	typedef enum logic [CMD_W-1:0] {
		CMD_LOAD    = 2'd0,
		CMD_TRI     = 2'd1,
		CMD_RESTART = 2'd2
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_OK      = 2'd0,
		STAT_FULL    = 2'd1,
		STAT_UNKNOWN = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_COMMIT,
		ST_TRI,
		ST_RESP
	} state_t;

	// One compare result leaving the distance pipeline
	typedef struct packed {
		logic             vld;
		logic             hit;
		logic [IDX_W-1:0] idx;
	} cmp_t;

endpackage

### src/wvr_if.sv
// Interfaces: request and response channels of the vertex weld and remap block.
interface wvr_req_if;
	logic                                 valid;
	logic                                 ready;
	logic [wvr_pkg::CMD_W-1:0]            cmd;
	logic signed [wvr_pkg::COORD_W-1:0]   coord_x;
	logic signed [wvr_pkg::COORD_W-1:0]   coord_y;
	logic signed [wvr_pkg::COORD_W-1:0]   coord_z;
	logic                                 unlinked;
	logic [wvr_pkg::OUT_IDX_W-1:0]        corner_a;
	logic [wvr_pkg::OUT_IDX_W-1:0]        corner_b;
	logic [wvr_pkg::OUT_IDX_W-1:0]        corner_c;

	modport source (output valid, cmd, coord_x, coord_y, coord_z, unlinked,
		corner_a, corner_b, corner_c, input ready);
	modport sink (input valid, cmd, coord_x, coord_y, coord_z, unlinked,
		corner_a, corner_b, corner_c, output ready);
endinterface

interface wvr_rsp_if;
	logic                            valid;
	logic                            ready;
	logic [wvr_pkg::OUT_IDX_W-1:0]   new_first;
	logic [wvr_pkg::OUT_IDX_W-1:0]   new_second;
	logic [wvr_pkg::OUT_IDX_W-1:0]   new_third;
	logic                            merged;
	logic [wvr_pkg::STATUS_W-1:0]    status;

	modport source (output valid, new_first, new_second, new_third, merged, status,
		input ready);
	modport sink (input valid, new_first, new_second, new_third, merged, status,
		output ready);
endinterface

### src/wvr_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module wvr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### src/wvr_dist.sv
// Distance pipeline: squared-distance test of the probe against one survivor per cycle.
module wvr_dist (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                issue_vld,
	input  logic [wvr_pkg::IDX_W-1:0]           issue_idx,
	input  logic signed [wvr_pkg::COORD_W-1:0]  probe_x,
	input  logic signed [wvr_pkg::COORD_W-1:0]  probe_y,
	input  logic signed [wvr_pkg::COORD_W-1:0]  probe_z,
	input  logic [wvr_pkg::SURV_W-1:0]          surv,
	input  logic [wvr_pkg::TOL_W-1:0]           tol,
	output wvr_pkg::cmp_t                       res
);

	localparam int CW = wvr_pkg::COORD_W;
	localparam int TW = wvr_pkg::TOL_W;

	logic                          vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic [wvr_pkg::IDX_W-1:0]     idx_s1, idx_s2, idx_s3, idx_s4, idx_s5;
	logic [TW-1:0]                 adx_s2, ady_s2, adz_s2;
	logic                          far_s2, far_s3, far_s4;
	logic [2*TW-1:0]               sqx_s3, sqy_s3, sqz_s3;
	logic [wvr_pkg::SUM_W-1:0]     sum_s4;
	logic                          hit_s5;
	logic [wvr_pkg::TOL_SQ_W-1:0]  tol_sq_q;

	logic [CW:0] mx, my, mz;

	// |a - b| over 33 bits; at most 2^32 - 1
	function automatic logic [CW:0] mag(input logic signed [CW-1:0] a,
		input logic signed [CW-1:0] b);
		logic signed [CW:0] d;
		d = {a[CW-1], a} - {b[CW-1], b};
		return d[CW] ? (CW+1)'(-d) : (CW+1)'(d);
	endfunction

	assign mx = mag(probe_x, surv[CW-1:0]);
	assign my = mag(probe_y, surv[2*CW-1:CW]);
	assign mz = mag(probe_z, surv[3*CW-1:2*CW]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= issue_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		tol_sq_q <= {{TW{1'b0}}, tol} * {{TW{1'b0}}, tol};
		idx_s1   <= issue_idx;
		// s2: axis distances; an axis at or past tol rules the survivor out
		idx_s2   <= idx_s1;
		adx_s2   <= mx[TW-1:0];
		ady_s2   <= my[TW-1:0];
		adz_s2   <= mz[TW-1:0];
		far_s2   <= (mx >= (CW+1)'(tol)) || (my >= (CW+1)'(tol)) || (mz >= (CW+1)'(tol));
		// s3: squares
		idx_s3   <= idx_s2;
		far_s3   <= far_s2;
		sqx_s3   <= {{TW{1'b0}}, adx_s2} * {{TW{1'b0}}, adx_s2};
		sqy_s3   <= {{TW{1'b0}}, ady_s2} * {{TW{1'b0}}, ady_s2};
		sqz_s3   <= {{TW{1'b0}}, adz_s2} * {{TW{1'b0}}, adz_s2};
		// s4: sum, below 3 * 2^62
		idx_s4   <= idx_s3;
		far_s4   <= far_s3;
		sum_s4   <= wvr_pkg::SUM_W'(sqx_s3) + wvr_pkg::SUM_W'(sqy_s3)
			+ wvr_pkg::SUM_W'(sqz_s3);
		// s5: strict compare against tol squared
		idx_s5   <= idx_s4;
		hit_s5   <= !far_s4 && (sum_s4 < wvr_pkg::SUM_W'(tol_sq_q));
	end

	assign res.vld = vld_s5;
	assign res.hit = hit_s5;
	assign res.idx = idx_s5;

endmodule

### src/mesh_vertex_weld_remap.sv
// Top level: vertex welding by distance tolerance with old-to-new index remapping.
// A load-vertex request, unless the store is full, streams every stored survivor,
// one per cycle, through a five-stage squared-distance pipeline fed from the
// survivor RAM; the survivor count and the single RAM read port set the length of
// the scan. The last survivor that matches wins, otherwise the vertex is appended
// as a new survivor. A remap-triangle request reads the three corners from the
// remap RAM one after another. Restart, unlinked triangles and unknown commands
// give no response and leave the block idle. The block takes no new request while
// one is at work; a finished response waits in an output register, so the next
// request can be taken before it leaves. The user must write distance_tol through
// cfg_we/cfg_wdata only while idle; the block itself does not enforce this.
// RAM contents are not cleared: only entries below the counts are ever used.
module mesh_vertex_weld_remap (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [wvr_pkg::TOL_W-1:0]    cfg_wdata,
	wvr_req_if.sink                      req,
	wvr_rsp_if.source                    rsp
);

	localparam int IW = wvr_pkg::IDX_W;
	localparam int NW = wvr_pkg::CNT_W;
	localparam int OW = wvr_pkg::OUT_IDX_W;
	localparam int CW = wvr_pkg::COORD_W;

	wvr_pkg::state_t state_q, state_d;

	logic [wvr_pkg::TOL_W-1:0]  tol_q;
	logic [NW-1:0]              surv_cnt_q, loaded_cnt_q;
	logic [IW-1:0]              scan_idx_q, last_idx;
	logic                       found_q;
	logic [IW-1:0]              hit_q;
	logic signed [CW-1:0]       probe_x_q, probe_y_q, probe_z_q;
	logic [OW-1:0]              corner_a_q, corner_b_q, corner_c_q;
	logic [2:0]                 bad_q;
	logic [1:0]                 step_q;

	// pending response, then the output register
	logic [OW-1:0]              pend_first_q, pend_second_q, pend_third_q;
	logic                       pend_merged_q;
	wvr_pkg::status_t           pend_status_q;
	logic                       out_vld_q;
	logic [OW-1:0]              out_first_q, out_second_q, out_third_q;
	logic                       out_merged_q;
	wvr_pkg::status_t           out_status_q;

	logic                       acc, full, scan_issue, surv_we, remap_we, resp_load;
	logic [IW-1:0]              remap_raddr;
	logic [IW-1:0]              remap_rdata;
	logic [wvr_pkg::SURV_W-1:0] surv_rdata;
	wvr_pkg::cmp_t              cmp;

	assign req.ready = (state_q == wvr_pkg::ST_IDLE);
	assign acc       = req.valid && req.ready;
	assign full      = (loaded_cnt_q == NW'(wvr_pkg::MAX_VERTICES));
	assign last_idx  = IW'(surv_cnt_q - NW'(1));
	assign resp_load = (state_q == wvr_pkg::ST_RESP) && (!out_vld_q || rsp.ready);

	always_comb begin
		unique case (step_q)
			2'd0:    remap_raddr = IW'(corner_a_q);
			2'd1:    remap_raddr = IW'(corner_b_q);
			default: remap_raddr = IW'(corner_c_q);
		endcase
	end

	// Sequencer: next state and RAM strobes
	always_comb begin
		state_d    = state_q;
		scan_issue = 1'b0;
		surv_we    = 1'b0;
		remap_we   = 1'b0;
		unique case (state_q)
			wvr_pkg::ST_IDLE: begin
				if (acc) begin
					unique case (req.cmd)
						wvr_pkg::CMD_LOAD: begin
							if (full) begin
								state_d = wvr_pkg::ST_RESP;
							end else if (surv_cnt_q == '0) begin
								state_d = wvr_pkg::ST_COMMIT;
							end else begin
								state_d = wvr_pkg::ST_SCAN;
							end
						end
						wvr_pkg::CMD_TRI: begin
							if (!req.unlinked) begin
								state_d = wvr_pkg::ST_TRI;
							end
						end
						default: ;
					endcase
				end
			end
			wvr_pkg::ST_SCAN: begin
				scan_issue = 1'b1;
				if (scan_idx_q == last_idx) begin
					state_d = wvr_pkg::ST_DRAIN;
				end
			end
			wvr_pkg::ST_DRAIN: begin
				// results come back in order, so the last survivor closes the scan
				if (cmp.vld && cmp.idx == last_idx) begin
					state_d = wvr_pkg::ST_COMMIT;
				end
			end
			wvr_pkg::ST_COMMIT: begin
				surv_we  = !found_q;
				remap_we = 1'b1;
				state_d  = wvr_pkg::ST_RESP;
			end
			wvr_pkg::ST_TRI: begin
				if (step_q == 2'd3) begin
					state_d = wvr_pkg::ST_RESP;
				end
			end
			wvr_pkg::ST_RESP: begin
				if (resp_load) begin
					state_d = wvr_pkg::ST_IDLE;
				end
			end
			default: state_d = wvr_pkg::ST_IDLE;
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= wvr_pkg::ST_IDLE;
			tol_q        <= '0;
			surv_cnt_q   <= '0;
			loaded_cnt_q <= '0;
			scan_idx_q   <= '0;
			found_q      <= 1'b0;
			step_q       <= '0;
			out_vld_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				tol_q <= cfg_wdata;
			end
			if (acc && req.cmd == wvr_pkg::CMD_RESTART) begin
				surv_cnt_q   <= '0;
				loaded_cnt_q <= '0;
			end
			if (acc) begin
				scan_idx_q <= '0;
				found_q    <= 1'b0;
				step_q     <= '0;
			end
			if (scan_issue) begin
				scan_idx_q <= scan_idx_q + IW'(1);
			end
			if (cmp.vld && cmp.hit) begin
				found_q <= 1'b1;
			end
			if (state_q == wvr_pkg::ST_COMMIT) begin
				loaded_cnt_q <= loaded_cnt_q + NW'(1);
				if (!found_q) begin
					surv_cnt_q <= surv_cnt_q + NW'(1);
				end
			end
			if (state_q == wvr_pkg::ST_TRI) begin
				step_q <= step_q + 2'd1;
			end
			if (resp_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Request payload and response build-up
	always_ff @(posedge clk) begin
		if (acc) begin
			probe_x_q     <= req.coord_x;
			probe_y_q     <= req.coord_y;
			probe_z_q     <= req.coord_z;
			corner_a_q    <= req.corner_a;
			corner_b_q    <= req.corner_b;
			corner_c_q    <= req.corner_c;
			bad_q[0]      <= 32'(req.corner_a) >= 32'(loaded_cnt_q);
			bad_q[1]      <= 32'(req.corner_b) >= 32'(loaded_cnt_q);
			bad_q[2]      <= 32'(req.corner_c) >= 32'(loaded_cnt_q);
			pend_first_q  <= '0;
			pend_second_q <= '0;
			pend_third_q  <= '0;
			pend_merged_q <= 1'b0;
			// full store answers straight away; the others overwrite this later
			pend_status_q <= full ? wvr_pkg::STAT_FULL : wvr_pkg::STAT_OK;
		end
		if (cmp.vld && cmp.hit) begin
			hit_q <= cmp.idx;
		end
		if (state_q == wvr_pkg::ST_COMMIT) begin
			pend_first_q  <= found_q ? OW'(hit_q) : OW'(surv_cnt_q);
			pend_merged_q <= found_q;
			pend_status_q <= wvr_pkg::STAT_OK;
		end
		if (state_q == wvr_pkg::ST_TRI) begin
			// read data arrives in the step after its address
			case (step_q)
				2'd1: pend_first_q  <= bad_q[0] ? '0 : OW'(remap_rdata);
				2'd2: pend_second_q <= bad_q[1] ? '0 : OW'(remap_rdata);
				2'd3: pend_third_q  <= bad_q[2] ? '0 : OW'(remap_rdata);
				default: ;
			endcase
			if (step_q == 2'd0) begin
				pend_status_q <= (|bad_q) ? wvr_pkg::STAT_UNKNOWN : wvr_pkg::STAT_OK;
			end
		end
		if (resp_load) begin
			out_first_q  <= pend_first_q;
			out_second_q <= pend_second_q;
			out_third_q  <= pend_third_q;
			out_merged_q <= pend_merged_q;
			out_status_q <= pend_status_q;
		end
	end

	assign rsp.valid      = out_vld_q;
	assign rsp.new_first  = out_first_q;
	assign rsp.new_second = out_second_q;
	assign rsp.new_third  = out_third_q;
	assign rsp.merged     = out_merged_q;
	assign rsp.status     = out_status_q;

	// survivor coordinates, packed z:y:x
	wvr_ram #(
		.WIDTH (wvr_pkg::SURV_W),
		.DEPTH (wvr_pkg::MAX_VERTICES)
	) u_surv_ram (
		.clk   (clk),
		.we    (surv_we),
		.waddr (IW'(surv_cnt_q)),
		.wdata ({probe_z_q, probe_y_q, probe_x_q}),
		.raddr (scan_idx_q),
		.rdata (surv_rdata)
	);

	// old index -> new index
	wvr_ram #(
		.WIDTH (IW),
		.DEPTH (wvr_pkg::MAX_VERTICES)
	) u_remap_ram (
		.clk   (clk),
		.we    (remap_we),
		.waddr (IW'(loaded_cnt_q)),
		.wdata (found_q ? hit_q : IW'(surv_cnt_q)),
		.raddr (remap_raddr),
		.rdata (remap_rdata)
	);

	wvr_dist u_dist (
		.clk       (clk),
		.arst_n    (arst_n),
		.issue_vld (scan_issue),
		.issue_idx (scan_idx_q),
		.probe_x   (probe_x_q),
		.probe_y   (probe_y_q),
		.probe_z   (probe_z_q),
		.surv      (surv_rdata),
		.tol       (tol_q),
		.res       (cmp)
	);

endmodule

### src/wvr_chk.sv
// Checker: port-level assertions for the vertex weld and remap block, bound to the top.
module wvr_chk (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           req_valid,
	input  logic                           req_ready,
	input  logic [wvr_pkg::CMD_W-1:0]      req_cmd,
	input  logic                           req_unlinked,
	input  logic                           rsp_valid,
	input  logic                           rsp_ready,
	input  logic [wvr_pkg::OUT_IDX_W-1:0]  rsp_new_first,
	input  logic                           rsp_merged,
	input  logic [wvr_pkg::STATUS_W-1:0]   rsp_status
);

	// a stalled response holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_new_first)
			&& $stable(rsp_merged) && $stable(rsp_status))
		else $error("response dropped or changed while stalled");

	// a vertex load keeps the block busy in the cycle after it is taken
	a_load_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_cmd == wvr_pkg::CMD_LOAD |=> !req_ready)
		else $error("ready after vertex load");

	// restart and unlinked triangle requests, which give no response, stay idle at once
	a_no_rsp_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_cmd == wvr_pkg::CMD_RESTART
			|| (req_cmd == wvr_pkg::CMD_TRI && req_unlinked)) |=> req_ready)
		else $error("busy after a request that gives no response");

	// a merge only comes with ok status, and status is a known code
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (rsp_status == wvr_pkg::STAT_OK || rsp_status == wvr_pkg::STAT_FULL
			|| rsp_status == wvr_pkg::STAT_UNKNOWN)
			&& (!rsp_merged || rsp_status == wvr_pkg::STAT_OK))
		else $error("bad status or merge flag");

endmodule

bind mesh_vertex_weld_remap wvr_chk u_wvr_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.req_valid     (req.valid),
	.req_ready     (req.ready),
	.req_cmd       (req.cmd),
	.req_unlinked  (req.unlinked),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_new_first (rsp.new_first),
	.rsp_merged    (rsp.merged),
	.rsp_status    (rsp.status)
);
